@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Checks are clocked on clk and
// the plain form is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TSFKV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TSFKV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSFKV_ASSERT(lbl, prop, msg)
`define TSFKV_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ hw/rtl/tsfkv_pkg.sv @@
`timescale 1ns / 1ps
package tsfkv_pkg;

  typedef enum logic [1:0] {
    OP_WR  = 2'd0,
    OP_RD  = 2'd1,
    OP_DEL = 2'd2,
    OP_FMT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RS_OK       = 3'd0,
    RS_NOTFOUND = 3'd1,
    RS_NOSPACE  = 3'd2,
    RS_TOOLONG  = 3'd3,
    RS_CORRUPT  = 3'd4
  } status_t;

  // what the record-header walk is doing
  typedef enum logic [1:0] {
    CTX_FIND,
    CTX_STORE,
    CTX_COMPACT
  } ctx_t;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_H0,
    S_H1,
    S_H2,
    S_H3,
    S_INV,
    S_DEL,
    S_RDV,
    S_RDW,
    S_AHDR,
    S_ARD,
    S_AWR,
    S_CRD,
    S_CWR,
    S_MARK,
    S_ER,
    S_DONE
  } state_t;

  localparam logic [7:0] ERASED  = 8'hFF;
  localparam logic [7:0] IN_USE  = 8'hAA;
  localparam logic [7:0] KEY_NIL = 8'h00;
  localparam int STAGE_BYTES = 256;
  localparam int STAGE_AW    = 8;

endpackage

@@ hw/rtl/tsfkv_ram.sv @@
`timescale 1ns / 1ps
module tsfkv_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] addr,
  input  logic [W-1:0]         wdata,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hw/rtl/two_sector_flash_key_value_log.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Key-value log store over two flash-like sectors held in one byte RAM.
// Input channel (in_valid/in_ready): one beat per op. Write beats stage a
// data byte; the beat with in_last_byte set stores the record under in_key.
// Read beats return one data byte at in_byte_offset plus the record length,
// delete beats kill the live record, format beats erase both sectors.
// Result channel (out_valid/out_ready): exactly one result beat per input
// beat, in order, held in an output register.
// A lookup walks the record headers through the single RAM port, then fetches
// the data byte for a read. A store writes a header and then each staged data
// byte; a compaction copies each live record into the other sector and then
// erases the old sector. The worst case is a store that compacts.
// After reset the block clears the whole store to 0xFF, one byte a cycle,
// with in_ready low; the second sector is active.
// A finished result waits in the output register while out_ready is low;
// the next beat is still taken meanwhile, and its result is held back
// until the output register frees.
module two_sector_flash_key_value_log #(
  parameter int SECTOR_BYTES = 4096,
  parameter int HEADER_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_key,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic [7:0] in_byte_offset,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [7:0] out_read_value,
  output logic [7:0] out_record_length
);

  localparam int AW = $clog2(2 * SECTOR_BYTES);
  localparam int PW = $clog2(SECTOR_BYTES + 520);
  localparam int CW = AW + 1;
  localparam logic [PW+1:0] SB_X  = (PW+2)'(SECTOR_BYTES);
  localparam logic [PW+1:0] SB2_X = (PW+2)'(2 * SECTOR_BYTES);
  localparam logic [PW:0]   SB_C  = (PW+1)'(SECTOR_BYTES);
  localparam logic [PW-1:0] HB_P  = PW'(HEADER_BYTES);

  // byte address of an offset within a sector, wrapping over the store
  function automatic logic [AW-1:0] loc(input logic sec, input logic [PW-1:0] off);
    logic [PW+1:0] s;
    s = (sec ? SB_X : '0) + {2'b00, off};
    if (s >= SB2_X) begin
      s = s - SB2_X;
    end
    return s[AW-1:0];
  endfunction

  tsfkv_pkg::state_t  st_r, st_nxt;
  tsfkv_pkg::ctx_t    ctx_r, ctx_nxt;
  tsfkv_pkg::op_t     op_r, op_nxt;
  tsfkv_pkg::status_t res_status_r, res_status_nxt, out_status_r;
  logic [7:0]    key_r, key_nxt, offs_r, offs_nxt, len_r, len_nxt;
  logic [7:0]    b0_r, b0_nxt, b1_r, b1_nxt, b2_r, b2_nxt;
  logic [7:0]    res_val_r, res_val_nxt, res_len_r, res_len_nxt;
  logic [7:0]    out_val_r, out_len_r;
  logic [PW-1:0] pos_r, pos_nxt, npos_r, npos_nxt, where_r, where_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [8:0]    stg_cnt_r, stg_cnt_nxt;
  logic          ovf_r, ovf_nxt, dirty_r, dirty_nxt, swapped_r, swapped_nxt;
  logic          act_r, act_nxt, fmt_r, fmt_nxt, out_valid_r, out_valid_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          stg_we;
  logic [tsfkv_pkg::STAGE_AW-1:0] stg_addr;
  logic [7:0]    stg_rdata;

  // decode helpers
  logic          in_rsvd, too_long, find_stop, store_stop;
  logic          b0_ff, b0_zero, hdr_live, key_hit, offs_in, out_free;
  logic [PW-1:0] step;

  assign in_rsvd    = (in_key == tsfkv_pkg::KEY_NIL) || (in_key == tsfkv_pkg::ERASED);
  assign too_long   = ovf_r || (stg_cnt_r >= 9'd255);
  assign find_stop  = ({1'b0, pos_r} + (PW+1)'(3)) > SB_C;
  assign store_stop = ({1'b0, pos_r} + (PW+1)'(len_r) + (PW+1)'(3)) > SB_C;
  assign b0_ff      = (b0_r == tsfkv_pkg::ERASED);
  assign b0_zero    = (b0_r == tsfkv_pkg::KEY_NIL);
  assign hdr_live   = (b1_r == (b0_r ^ tsfkv_pkg::ERASED));
  assign key_hit    = (b0_r == key_r);
  assign offs_in    = (offs_r < ram_rdata);
  assign step       = pos_r + PW'(ram_rdata) + PW'(3);
  assign out_free   = !out_valid_r || out_ready;

  tsfkv_ram #(.W(8), .D(2 * SECTOR_BYTES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  tsfkv_ram #(.W(8), .D(tsfkv_pkg::STAGE_BYTES)) u_stage (
    .clk   (clk),
    .we    (stg_we),
    .addr  (stg_addr),
    .wdata (in_data_byte),
    .rdata (stg_rdata)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      tsfkv_pkg::S_CLR: begin
        if (cnt_r == CW'(2 * SECTOR_BYTES - 1)) begin
          st_nxt = fmt_r ? tsfkv_pkg::S_DONE : tsfkv_pkg::S_IDLE;
        end
      end
      tsfkv_pkg::S_IDLE: begin
        if (in_valid) begin
          case (tsfkv_pkg::op_t'(in_op))
            tsfkv_pkg::OP_WR: begin
              st_nxt = (in_last_byte && !too_long && !in_rsvd) ? tsfkv_pkg::S_H0
                                                               : tsfkv_pkg::S_DONE;
            end
            tsfkv_pkg::OP_FMT: st_nxt = tsfkv_pkg::S_CLR;
            default: st_nxt = in_rsvd ? tsfkv_pkg::S_DONE : tsfkv_pkg::S_H0;
          endcase
        end
      end
      tsfkv_pkg::S_H0: begin
        case (ctx_r)
          tsfkv_pkg::CTX_FIND: begin
            if (!find_stop) st_nxt = tsfkv_pkg::S_H1;
            else if (op_r != tsfkv_pkg::OP_WR) st_nxt = tsfkv_pkg::S_DONE;
          end
          tsfkv_pkg::CTX_STORE: begin
            if (!store_stop) st_nxt = tsfkv_pkg::S_H1;
            else if (!(dirty_r && !swapped_r)) st_nxt = tsfkv_pkg::S_DONE;
          end
          default: st_nxt = find_stop ? tsfkv_pkg::S_MARK : tsfkv_pkg::S_H1;
        endcase
      end
      tsfkv_pkg::S_H1: st_nxt = tsfkv_pkg::S_H2;
      tsfkv_pkg::S_H2: st_nxt = tsfkv_pkg::S_H3;
      tsfkv_pkg::S_H3: begin
        case (ctx_r)
          tsfkv_pkg::CTX_FIND: begin
            if (key_hit && hdr_live) begin
              case (op_r)
                tsfkv_pkg::OP_WR:  st_nxt = tsfkv_pkg::S_INV;
                tsfkv_pkg::OP_DEL: st_nxt = tsfkv_pkg::S_DEL;
                default: st_nxt = offs_in ? tsfkv_pkg::S_RDV : tsfkv_pkg::S_DONE;
              endcase
            end else if (key_hit || (!b0_zero && !b0_ff)) begin
              st_nxt = tsfkv_pkg::S_H0;
            end else begin
              st_nxt = (op_r == tsfkv_pkg::OP_WR) ? tsfkv_pkg::S_H0 : tsfkv_pkg::S_DONE;
            end
          end
          tsfkv_pkg::CTX_STORE: begin
            if (b0_ff) st_nxt = tsfkv_pkg::S_AHDR;
            else if (!b0_zero) st_nxt = tsfkv_pkg::S_H0;
            else st_nxt = tsfkv_pkg::S_DONE;
          end
          default: begin
            if (b0_ff || b0_zero) st_nxt = tsfkv_pkg::S_MARK;
            else if (hdr_live) st_nxt = tsfkv_pkg::S_CRD;
            else st_nxt = tsfkv_pkg::S_H0;
          end
        endcase
      end
      tsfkv_pkg::S_INV: st_nxt = tsfkv_pkg::S_H0;
      tsfkv_pkg::S_DEL: st_nxt = tsfkv_pkg::S_DONE;
      tsfkv_pkg::S_RDV: st_nxt = tsfkv_pkg::S_RDW;
      tsfkv_pkg::S_RDW: st_nxt = tsfkv_pkg::S_DONE;
      tsfkv_pkg::S_AHDR: begin
        if (cnt_r == CW'(2)) begin
          st_nxt = (len_r == 8'd0) ? tsfkv_pkg::S_DONE : tsfkv_pkg::S_ARD;
        end
      end
      tsfkv_pkg::S_ARD: st_nxt = tsfkv_pkg::S_AWR;
      tsfkv_pkg::S_AWR: begin
        st_nxt = (cnt_r + CW'(1) == CW'(len_r)) ? tsfkv_pkg::S_DONE : tsfkv_pkg::S_ARD;
      end
      tsfkv_pkg::S_CRD: st_nxt = tsfkv_pkg::S_CWR;
      tsfkv_pkg::S_CWR: begin
        st_nxt = (cnt_r + CW'(1) == CW'(b2_r) + CW'(3)) ? tsfkv_pkg::S_H0
                                                       : tsfkv_pkg::S_CRD;
      end
      tsfkv_pkg::S_MARK: st_nxt = tsfkv_pkg::S_ER;
      tsfkv_pkg::S_ER: begin
        if (cnt_r == CW'(SECTOR_BYTES - 1)) st_nxt = tsfkv_pkg::S_H0;
      end
      tsfkv_pkg::S_DONE: begin
        if (out_free) st_nxt = tsfkv_pkg::S_IDLE;
      end
      default: st_nxt = tsfkv_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    ctx_nxt = ctx_r;         op_nxt = op_r;           key_nxt = key_r;
    offs_nxt = offs_r;       len_nxt = len_r;         b0_nxt = b0_r;
    b1_nxt = b1_r;           b2_nxt = b2_r;           pos_nxt = pos_r;
    npos_nxt = npos_r;       where_nxt = where_r;     cnt_nxt = cnt_r;
    stg_cnt_nxt = stg_cnt_r; ovf_nxt = ovf_r;         dirty_nxt = dirty_r;
    swapped_nxt = swapped_r; act_nxt = act_r;         fmt_nxt = fmt_r;
    res_status_nxt = res_status_r;
    res_val_nxt = res_val_r; res_len_nxt = res_len_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we = 1'b0;
    ram_addr = loc(act_r, pos_r);
    ram_wdata = tsfkv_pkg::ERASED;
    stg_we = 1'b0;
    stg_addr = stg_cnt_r[tsfkv_pkg::STAGE_AW-1:0];

    case (st_r)
      tsfkv_pkg::S_CLR: begin
        ram_we = 1'b1;
        ram_addr = cnt_r[AW-1:0];
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(2 * SECTOR_BYTES - 1)) begin
          cnt_nxt = '0;
          fmt_nxt = 1'b0;
        end
      end
      tsfkv_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt = tsfkv_pkg::op_t'(in_op);
          key_nxt = in_key;
          offs_nxt = in_byte_offset;
          pos_nxt = HB_P;
          ctx_nxt = tsfkv_pkg::CTX_FIND;
          res_status_nxt = tsfkv_pkg::RS_OK;
          res_val_nxt = 8'd0;
          res_len_nxt = 8'd0;
          case (tsfkv_pkg::op_t'(in_op))
            tsfkv_pkg::OP_WR: begin
              // stage the byte, or note the overflow
              if (stg_cnt_r < 9'(tsfkv_pkg::STAGE_BYTES)) begin
                stg_we = 1'b1;
                stg_cnt_nxt = stg_cnt_r + 9'd1;
              end else begin
                ovf_nxt = 1'b1;
              end
              if (in_last_byte) begin
                len_nxt = stg_cnt_r[7:0] + 8'd1;
                if (too_long) res_status_nxt = tsfkv_pkg::RS_TOOLONG;
                else if (in_rsvd) res_status_nxt = tsfkv_pkg::RS_CORRUPT;
                stg_cnt_nxt = '0;
                ovf_nxt = 1'b0;
              end
            end
            tsfkv_pkg::OP_FMT: begin
              cnt_nxt = '0;
              fmt_nxt = 1'b1;
            end
            default: begin
              if (in_rsvd) res_status_nxt = tsfkv_pkg::RS_NOTFOUND;
            end
          endcase
        end
      end
      tsfkv_pkg::S_H0: begin
        case (ctx_r)
          tsfkv_pkg::CTX_FIND: begin
            if (find_stop) begin
              if (op_r == tsfkv_pkg::OP_WR) begin
                ctx_nxt = tsfkv_pkg::CTX_STORE;
                pos_nxt = HB_P;
                dirty_nxt = 1'b0;
                swapped_nxt = 1'b0;
              end else begin
                res_status_nxt = tsfkv_pkg::RS_NOTFOUND;
              end
            end
          end
          tsfkv_pkg::CTX_STORE: begin
            if (store_stop) begin
              if (dirty_r && !swapped_r) begin
                ctx_nxt = tsfkv_pkg::CTX_COMPACT;
                pos_nxt = HB_P;
                npos_nxt = HB_P;
              end else begin
                res_status_nxt = tsfkv_pkg::RS_NOSPACE;
              end
            end
          end
          default: ;
        endcase
      end
      tsfkv_pkg::S_H1: begin
        ram_addr = loc(act_r, pos_r + PW'(1));
        b0_nxt = ram_rdata;
      end
      tsfkv_pkg::S_H2: begin
        ram_addr = loc(act_r, pos_r + PW'(2));
        b1_nxt = ram_rdata;
      end
      tsfkv_pkg::S_H3: begin
        b2_nxt = ram_rdata;
        cnt_nxt = '0;
        case (ctx_r)
          tsfkv_pkg::CTX_FIND: begin
            if (key_hit && hdr_live) begin
              where_nxt = pos_r;
              if (op_r != tsfkv_pkg::OP_WR) res_len_nxt = ram_rdata;
            end else if (key_hit || (!b0_zero && !b0_ff)) begin
              pos_nxt = step;
            end else if (op_r == tsfkv_pkg::OP_WR) begin
              ctx_nxt = tsfkv_pkg::CTX_STORE;
              pos_nxt = HB_P;
              dirty_nxt = 1'b0;
              swapped_nxt = 1'b0;
            end else begin
              res_status_nxt = tsfkv_pkg::RS_NOTFOUND;
            end
          end
          tsfkv_pkg::CTX_STORE: begin
            if (!b0_ff && !b0_zero) begin
              pos_nxt = step;
              if (!hdr_live) dirty_nxt = 1'b1;
            end else if (b0_zero) begin
              res_status_nxt = tsfkv_pkg::RS_CORRUPT;
            end
          end
          default: begin
            if (!b0_ff && !b0_zero && !hdr_live) pos_nxt = step;
          end
        endcase
      end
      tsfkv_pkg::S_INV, tsfkv_pkg::S_DEL: begin
        // kill the live copy by zeroing its inverted key
        ram_we = 1'b1;
        ram_addr = loc(act_r, where_r + PW'(1));
        ram_wdata = tsfkv_pkg::KEY_NIL;
        ctx_nxt = tsfkv_pkg::CTX_STORE;
        pos_nxt = HB_P;
        dirty_nxt = 1'b0;
        swapped_nxt = 1'b0;
      end
      tsfkv_pkg::S_RDV: begin
        ram_addr = loc(act_r, where_r + PW'(3) + PW'(offs_r));
      end
      tsfkv_pkg::S_RDW: begin
        res_val_nxt = ram_rdata;
      end
      tsfkv_pkg::S_AHDR: begin
        ram_we = 1'b1;
        ram_addr = loc(act_r, pos_r + PW'(cnt_r[1:0]));
        case (cnt_r[1:0])
          2'd0: ram_wdata = key_r;
          2'd1: ram_wdata = key_r ^ tsfkv_pkg::ERASED;
          default: ram_wdata = len_r;
        endcase
        cnt_nxt = (cnt_r == CW'(2)) ? '0 : cnt_r + CW'(1);
      end
      tsfkv_pkg::S_ARD: begin
        stg_addr = cnt_r[tsfkv_pkg::STAGE_AW-1:0];
      end
      tsfkv_pkg::S_AWR: begin
        ram_we = 1'b1;
        ram_addr = loc(act_r, pos_r + PW'(3) + PW'(cnt_r));
        ram_wdata = stg_rdata;
        cnt_nxt = cnt_r + CW'(1);
      end
      tsfkv_pkg::S_CRD: begin
        ram_addr = loc(act_r, pos_r + PW'(cnt_r));
      end
      tsfkv_pkg::S_CWR: begin
        // copy one byte of a live record into the other sector
        ram_we = 1'b1;
        ram_addr = loc(!act_r, npos_r + PW'(cnt_r));
        ram_wdata = ram_rdata;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r + CW'(1) == CW'(b2_r) + CW'(3)) begin
          npos_nxt = npos_r + PW'(b2_r) + PW'(3);
          pos_nxt = pos_r + PW'(b2_r) + PW'(3);
          cnt_nxt = '0;
        end
      end
      tsfkv_pkg::S_MARK: begin
        ram_we = 1'b1;
        ram_addr = loc(!act_r, '0);
        ram_wdata = tsfkv_pkg::IN_USE;
        cnt_nxt = '0;
      end
      tsfkv_pkg::S_ER: begin
        ram_we = 1'b1;
        ram_addr = loc(act_r, PW'(cnt_r));
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(SECTOR_BYTES - 1)) begin
          act_nxt = !act_r;
          swapped_nxt = 1'b1;
          dirty_nxt = 1'b0;
          pos_nxt = HB_P;
          ctx_nxt = tsfkv_pkg::CTX_STORE;
          cnt_nxt = '0;
        end
      end
      tsfkv_pkg::S_DONE: begin
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tsfkv_pkg::S_CLR;
      cnt_r <= '0;
      act_r <= 1'b1;
      stg_cnt_r <= '0;
      ovf_r <= 1'b0;
      fmt_r <= 1'b0;
      out_valid_r <= 1'b0;
      ctx_r <= tsfkv_pkg::CTX_FIND;
      op_r <= tsfkv_pkg::OP_WR;
      dirty_r <= 1'b0;
      swapped_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      act_r <= act_nxt;
      stg_cnt_r <= stg_cnt_nxt;
      ovf_r <= ovf_nxt;
      fmt_r <= fmt_nxt;
      out_valid_r <= out_valid_nxt;
      ctx_r <= ctx_nxt;
      op_r <= op_nxt;
      dirty_r <= dirty_nxt;
      swapped_r <= swapped_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    offs_r <= offs_nxt;
    len_r <= len_nxt;
    b0_r <= b0_nxt;
    b1_r <= b1_nxt;
    b2_r <= b2_nxt;
    pos_r <= pos_nxt;
    npos_r <= npos_nxt;
    where_r <= where_nxt;
    res_status_r <= res_status_nxt;
    res_val_r <= res_val_nxt;
    res_len_r <= res_len_nxt;
    if (st_r == tsfkv_pkg::S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_val_r <= res_val_r;
      out_len_r <= res_len_r;
    end
  end

  assign in_ready          = (st_r == tsfkv_pkg::S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_read_value    = out_val_r;
  assign out_record_length = out_len_r;

  `TSFKV_ASSERT(a_stg_bound, stg_cnt_r <= 9'd256, "staging count past buffer size")
  `TSFKV_ASSERT(a_act_stable, (st_r != tsfkv_pkg::S_ER) |=> $stable(act_r), "sector flip outside erase")
  `TSFKV_ASSERT(a_no_wr_idle, !(st_r == tsfkv_pkg::S_IDLE && ram_we), "store written while idle")
  `TSFKV_ASSERT_RST(a_rst_out, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule
